/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled during reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("display assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("display assertion failed");

`endif

/* src/sssd_pkg.sv */
`default_nettype none

package sssd_pkg;

  // Command codes.
  typedef enum logic [3:0] {
    OP_INIT      = 4'd0,
    OP_SHOW_WAIT = 4'd1,
    OP_ERROR     = 4'd2,
    OP_ROUTER    = 4'd3,
    OP_DHCP      = 4'd4,
    OP_SET_DOT   = 4'd5,
    OP_CLR_DOT   = 4'd6,
    OP_CLEAR     = 4'd7,
    OP_TOG_COLON = 4'd8
  } op_e;

  typedef logic [7:0] seg_t;

  // One accepted command.
  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  bus_line;
    logic [7:0]  wait_minutes;
    logic [1:0]  wait_slot;
    logic [31:0] age_ms;
  } cmd_t;

  // The five display bytes, first position first.
  typedef struct packed {
    seg_t d0;
    seg_t d1;
    seg_t ind;
    seg_t d3;
    seg_t d4;
  } disp_t;

  localparam logic [31:0] STALE_LIMIT_RST = 32'd60000;

  // Indicator masks and bits of the middle byte.
  localparam seg_t IND_SLOT_KEEP  = 8'hF3;
  localparam seg_t IND_COLON_KEEP = 8'hFC;
  localparam seg_t IND_COLON      = 8'h02;
  localparam seg_t IND_DOT_KEEP   = 8'hEF;
  localparam seg_t IND_DOT        = 8'h10;

  // Fixed glyphs, one letter per position.
  localparam seg_t G_I = 8'b0011_0000;
  localparam seg_t G_N = 8'h54;
  localparam seg_t G_T = 8'b0111_1000;
  localparam seg_t G_E = 8'b0111_1001;
  localparam seg_t G_R = 8'b0101_0000;
  localparam seg_t G_C = 8'h58;
  localparam seg_t G_D = 8'b0101_1110;
  localparam seg_t G_H = 8'h74;
  localparam seg_t G_P = 8'b0111_0011;
  localparam seg_t G_BLANK = 8'h00;
  // Small letter i, segment e only.
  localparam seg_t G_SMALL_I = 8'h10;

  // Segment code of a decimal digit; anything above nine is blank.
  function automatic seg_t digit_glyph(logic [7:0] d);
    seg_t g;
    case (d)
      8'd0:    g = 8'b0011_1111;
      8'd1:    g = 8'h06;
      8'd2:    g = 8'h5B;
      8'd3:    g = 8'h4F;
      8'd4:    g = 8'h66;
      8'd5:    g = 8'h6D;
      8'd6:    g = 8'h7D;
      8'd7:    g = 8'h07;
      8'd8:    g = 8'h7F;
      8'd9:    g = 8'h6F;
      default: g = G_BLANK;
    endcase
    return g;
  endfunction

  // Quotient by ten of an 8-bit value via reciprocal multiply (exact for every 8-bit input).
  function automatic logic [7:0] div10(logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd205;
    return {3'd0, p[15:11]};
  endfunction

endpackage

`default_nettype wire

/* src/sssd_cmd_if.sv */
`default_nettype none

interface sssd_cmd_if;
  import sssd_pkg::*;

  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [7:0]  bus_line;
  logic [7:0]  wait_minutes;
  logic [1:0]  wait_slot;
  logic [31:0] age_ms;

  modport source (output valid, opcode, bus_line, wait_minutes, wait_slot, age_ms,
                  input ready);
  modport sink   (input valid, opcode, bus_line, wait_minutes, wait_slot, age_ms,
                  output ready);
endinterface

`default_nettype wire

/* src/sssd_disp_if.sv */
`default_nettype none

interface sssd_disp_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_zero;
  logic [7:0] digit_one;
  logic [7:0] indicator_byte;
  logic [7:0] digit_three;
  logic [7:0] digit_four;

  modport source (output valid, digit_zero, digit_one, indicator_byte, digit_three,
                  digit_four, input ready);
  modport sink   (input valid, digit_zero, digit_one, indicator_byte, digit_three,
                  digit_four, output ready);
endinterface

`default_nettype wire

/* src/sssd_in_stage.sv */
`default_nettype none

module sssd_in_stage import sssd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sssd_cmd_if.sink  cmd,
  input  wire logic advance_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  // The stage takes a transaction whenever it is empty or drains this cycle.
  assign cmd.ready = !valid_q || advance_i;
  assign take      = cmd.valid && cmd.ready;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (take) begin
      valid_d = 1'b1;
      cmd_d   = '{opcode: cmd.opcode, bus_line: cmd.bus_line,
                  wait_minutes: cmd.wait_minutes, wait_slot: cmd.wait_slot,
                  age_ms: cmd.age_ms};
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

`default_nettype wire

/* src/sssd_next.sv */
`default_nettype none

module sssd_next import sssd_pkg::*; (
  input  wire cmd_t  cmd_i,
  input  wire logic  stale_i,
  input  wire disp_t cur_i,
  output disp_t      nxt_o
);

  logic [7:0] line_q10, line_r10, wait_q10, wait_r10;
  seg_t       ind;

  // Decimal split of line and wait.
  always_comb begin
    line_q10 = div10(cmd_i.bus_line);
    line_r10 = cmd_i.bus_line - (line_q10 * 8'd10);
    wait_q10 = div10(cmd_i.wait_minutes);
    wait_r10 = cmd_i.wait_minutes - (wait_q10 * 8'd10);
  end

  // Indicator update for show wait: slot index, then colon when stale.
  always_comb begin
    ind = (cur_i.ind & IND_SLOT_KEEP) | {4'd0, cmd_i.wait_slot, 2'd0};
    if (stale_i) begin
      ind = (ind & IND_COLON_KEEP) | IND_COLON;
    end
  end

  // Command decode and byte update.
  always_comb begin
    nxt_o = cur_i;
    case (op_e'(cmd_i.opcode))
      OP_INIT: begin
        nxt_o = '{d0: G_I, d1: G_N, ind: G_BLANK, d3: G_SMALL_I, d4: G_T};
      end
      OP_SHOW_WAIT: begin
        nxt_o.ind = ind;
        if (cmd_i.bus_line == 8'd0) begin
          nxt_o.d0 = G_BLANK;
          nxt_o.d1 = G_BLANK;
          nxt_o.d3 = G_BLANK;
          nxt_o.d4 = G_BLANK;
        end else begin
          if (cmd_i.bus_line < 8'd10) begin
            nxt_o.d0 = digit_glyph(cmd_i.bus_line);
            nxt_o.d1 = G_BLANK;
          end else begin
            nxt_o.d0 = digit_glyph(line_q10);
            nxt_o.d1 = digit_glyph(line_r10);
          end
          // A wait of 100 or more leaves the wait digits as they are.
          if (cmd_i.wait_minutes < 8'd10) begin
            nxt_o.d3 = G_BLANK;
            nxt_o.d4 = digit_glyph(cmd_i.wait_minutes);
          end else if (cmd_i.wait_minutes < 8'd100) begin
            nxt_o.d3 = digit_glyph(wait_q10);
            nxt_o.d4 = digit_glyph(wait_r10);
          end
        end
      end
      OP_ERROR: begin
        nxt_o.d0 = G_E;
        nxt_o.d1 = G_R;
        nxt_o.d3 = G_R;
        nxt_o.d4 = G_BLANK;
      end
      OP_ROUTER: begin
        nxt_o.d0 = G_R;
        nxt_o.d1 = G_T;
        nxt_o.d3 = G_C;
        nxt_o.d4 = G_N;
      end
      OP_DHCP: begin
        nxt_o.d0 = G_D;
        nxt_o.d1 = G_H;
        nxt_o.d3 = G_C;
        nxt_o.d4 = G_P;
      end
      OP_SET_DOT: begin
        nxt_o.ind = (cur_i.ind & IND_DOT_KEEP) | IND_DOT;
      end
      OP_CLR_DOT: begin
        nxt_o.ind = cur_i.ind & IND_DOT_KEEP;
      end
      OP_CLEAR: begin
        nxt_o.d0 = G_BLANK;
        nxt_o.d1 = G_BLANK;
        nxt_o.d3 = G_BLANK;
        nxt_o.d4 = G_BLANK;
      end
      OP_TOG_COLON: begin
        nxt_o.ind = cur_i.ind ^ IND_COLON;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/seven_segment_status_display.sv */
// Five-position seven-segment status display controller.
// Commands arrive as transactions on the cmd channel (valid/ready); each one
// updates the five stored segment bytes and produces exactly one transaction
// on the disp channel carrying all five bytes after the update.
// The stale limit register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the block is idle, which the block does not enforce.
// It resets to 60000. Each command is registered first in the input register,
// then its result in the result register, which also holds the display state.
// Throughput: one command per cycle while the receiver does not stall; the
// whole update is a single pass of short logic, with divide by ten done as a
// reciprocal multiply.
// Reset clears all segment bytes, both valid flags and loads the stale limit.
// When the receiver stalls, the result holds, the input register still takes
// one more command, and then cmd.ready drops until the result is taken.
`default_nettype none

`include "assert_macros.svh"

module seven_segment_status_display import sssd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sssd_cmd_if.sink         cmd,
  sssd_disp_if.source      disp,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  logic [31:0] stale_limit_q;
  logic        stage_valid;
  cmd_t        stage_cmd;
  logic        advance;
  logic        stale;
  disp_t       bytes_q, bytes_d;
  logic        out_valid_q, out_valid_d;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_limit_q <= STALE_LIMIT_RST;
    end else if (cfg_we_i) begin
      stale_limit_q <= cfg_wdata_i;
    end
  end

  // The staged command moves on when the result register is free.
  assign advance = stage_valid && (!out_valid_q || disp.ready);

  sssd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd       (cmd),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .cmd_o     (stage_cmd)
  );

  assign stale = stage_cmd.age_ms > stale_limit_q;

  sssd_next u_next (
    .cmd_i   (stage_cmd),
    .stale_i (stale),
    .cur_i   (bytes_q),
    .nxt_o   (bytes_d)
  );

  // Result register doubles as display state.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (disp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bytes_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        bytes_q <= bytes_d;
      end
    end
  end

  assign disp.valid          = out_valid_q;
  assign disp.digit_zero     = bytes_q.d0;
  assign disp.digit_one      = bytes_q.d1;
  assign disp.indicator_byte = bytes_q.ind;
  assign disp.digit_three    = bytes_q.d3;
  assign disp.digit_four     = bytes_q.d4;

  // A clear command leaves all four digit positions blank.
  `ASSERT_NEXT(a_clear_blanks, clk_i, rst_ni,
               advance && (stage_cmd.opcode == OP_CLEAR),
               (bytes_q.d0 == G_BLANK) && (bytes_q.d1 == G_BLANK) &&
               (bytes_q.d3 == G_BLANK) && (bytes_q.d4 == G_BLANK))

  // Toggle colon flips only the colon bit of the indicator byte.
  `ASSERT_NEXT(a_colon_toggle, clk_i, rst_ni,
               advance && (stage_cmd.opcode == OP_TOG_COLON),
               bytes_q.ind == ($past(bytes_q.ind) ^ IND_COLON))

  // Show wait always lands the slot index in bits two and three.
  `ASSERT_NEXT(a_slot_bits, clk_i, rst_ni,
               advance && (stage_cmd.opcode == OP_SHOW_WAIT),
               bytes_q.ind[3:2] == $past(stage_cmd.wait_slot))

  // Display state only changes when a result is produced.
  `ASSERT_CLKD(a_state_moves_with_result, clk_i, rst_ni,
               !$stable(bytes_q) |-> out_valid_q)

endmodule

`default_nettype wire

/* tb/tb_seven_segment_status_display.sv */
`default_nettype none

module tb_seven_segment_status_display;
  import sssd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS = 160;

  localparam seg_t DIGIT_SEGS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // Tracks the five display bytes and the stale limit, and queues the display
  // contents that each accepted command should produce.
  class display_scoreboard;
    seg_t        shown [5];
    logic [31:0] stale_limit;
    disp_t       expected_q [$];
    int unsigned errors;

    function new();
      foreach (shown[i]) shown[i] = G_BLANK;
      stale_limit = STALE_LIMIT_RST;
      errors = 0;
    endfunction

    function void set_stale_limit(logic [31:0] value);
      stale_limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function seg_t digit_segs(int unsigned d);
      return (d > 9) ? G_BLANK : DIGIT_SEGS[d];
    endfunction

    function void put_glyphs(seg_t p0, seg_t p1, seg_t p3, seg_t p4);
      shown[0] = p0;
      shown[1] = p1;
      shown[3] = p3;
      shown[4] = p4;
    endfunction

    // Slot and stale indicator first, then the line and the waiting time.
    function void show_wait(cmd_t c);
      seg_t ind;
      ind = (shown[2] & IND_SLOT_KEEP) | {4'd0, c.wait_slot, 2'd0};
      if (c.age_ms > stale_limit) ind = (ind & IND_COLON_KEEP) | IND_COLON;
      shown[2] = ind;
      if (c.bus_line == 8'd0) begin
        put_glyphs(G_BLANK, G_BLANK, G_BLANK, G_BLANK);
        return;
      end
      if (c.bus_line < 8'd10) begin
        shown[0] = digit_segs(c.bus_line);
        shown[1] = G_BLANK;
      end else begin
        shown[0] = digit_segs(c.bus_line / 10);
        shown[1] = digit_segs(c.bus_line % 10);
      end
      // A wait of 100 minutes or more leaves the last two positions alone.
      if (c.wait_minutes < 8'd10) begin
        shown[3] = G_BLANK;
        shown[4] = digit_segs(c.wait_minutes);
      end else if (c.wait_minutes < 8'd100) begin
        shown[3] = digit_segs(c.wait_minutes / 10);
        shown[4] = digit_segs(c.wait_minutes % 10);
      end
    endfunction

    function void note_command(cmd_t c);
      case (c.opcode)
        OP_INIT: begin
          put_glyphs(G_I, G_N, G_SMALL_I, G_T);
          shown[2] = G_BLANK;
        end
        OP_SHOW_WAIT: show_wait(c);
        OP_ERROR:     put_glyphs(G_E, G_R, G_R, G_BLANK);
        OP_ROUTER:    put_glyphs(G_R, G_T, G_C, G_N);
        OP_DHCP:      put_glyphs(G_D, G_H, G_C, G_P);
        OP_SET_DOT:   shown[2] = (shown[2] & IND_DOT_KEEP) | IND_DOT;
        OP_CLR_DOT:   shown[2] = shown[2] & IND_DOT_KEEP;
        OP_CLEAR:     put_glyphs(G_BLANK, G_BLANK, G_BLANK, G_BLANK);
        OP_TOG_COLON: shown[2] = shown[2] ^ IND_COLON;
        default: ;
      endcase
      expected_q.push_back('{d0: shown[0], d1: shown[1], ind: shown[2],
                             d3: shown[3], d4: shown[4]});
    endfunction

    function void compare_field(string field, seg_t exp_val, seg_t act_val);
      if (exp_val !== act_val) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    function void check_result(disp_t got);
      disp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected display transaction: expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("digit_zero", want.d0, got.d0);
      compare_field("digit_one", want.d1, got.d1);
      compare_field("indicator_byte", want.ind, got.ind);
      compare_field("digit_three", want.d3, got.d3);
      compare_field("digit_four", want.d4, got.d4);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  sssd_cmd_if  cmd_bus ();
  sssd_disp_if disp_bus ();

  display_scoreboard board;

  // Idle controls for each side, and the request for a long receiver hold-off.
  bit          tx_gaps;
  bit          rx_gaps;
  bit          hold_req;
  int unsigned stall_cycles;
  logic [31:0] cur_limit;

  seven_segment_status_display dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd        (cmd_bus),
    .disp       (disp_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check every display transaction against the oldest queued expectation.
  always @(posedge clk_i) begin
    if (rst_ni && disp_bus.valid && disp_bus.ready) begin
      board.check_result('{d0: disp_bus.digit_zero, d1: disp_bus.digit_one,
                           ind: disp_bus.indicator_byte, d3: disp_bus.digit_three,
                           d4: disp_bus.digit_four});
    end
  end

  // Stop the run if neither channel moves a transaction for too long.
  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (disp_bus.valid && disp_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_seven_segment_status_display: errors");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when requested.
  initial begin
    disp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        disp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        disp_bus.ready <= !(rx_gaps && ($urandom_range(99) < 20));
      end
    end
  end

  // Offer one command and return at the edge where it is accepted. Valid is
  // left high so a following command goes out back to back.
  task automatic send_cmd(cmd_t c);
    while (tx_gaps && ($urandom_range(99) < 20)) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.opcode       <= c.opcode;
    cmd_bus.bus_line     <= c.bus_line;
    cmd_bus.wait_minutes <= c.wait_minutes;
    cmd_bus.wait_slot    <= c.wait_slot;
    cmd_bus.age_ms       <= c.age_ms;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    board.note_command(c);
  endtask

  task automatic send_fields(logic [3:0] op, logic [7:0] line, logic [7:0] mins,
                             logic [1:0] slot, logic [31:0] age);
    send_cmd('{opcode: op, bus_line: line, wait_minutes: mins, wait_slot: slot,
               age_ms: age});
  endtask

  // Stop offering and wait until every expected display has come back.
  task automatic drain();
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_stale_limit(logic [31:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_stale_limit(value);
    cur_limit = value;
  endtask

  function automatic logic [7:0] pick_number();
    case ($urandom_range(4))
      0:       return 8'd0;
      1:       return 8'($urandom_range(9, 1));
      2:       return 8'($urandom_range(99, 10));
      3:       return 8'($urandom_range(255, 100));
      default: return 8'($urandom);
    endcase
  endfunction

  // About half show-wait commands, half of all ages near the stale limit, plus the
  // other commands and a few unused codes.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) c.opcode = OP_SHOW_WAIT;
    else if (sel < 92) c.opcode = 4'($urandom_range(8));
    else c.opcode = 4'($urandom_range(15, 9));
    c.bus_line     = pick_number();
    c.wait_minutes = pick_number();
    c.wait_slot    = 2'($urandom);
    if ($urandom_range(1)) c.age_ms = cur_limit + 32'($urandom_range(4)) - 32'd2;
    else c.age_ms = $urandom;
    return c;
  endfunction

  task automatic random_phase(int unsigned count);
    repeat (count) send_cmd(random_cmd());
  endtask

  initial begin
    board = new();
    rst_ni               = 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    cmd_bus.valid        <= 1'b0;
    cmd_bus.opcode       <= '0;
    cmd_bus.bus_line     <= '0;
    cmd_bus.wait_minutes <= '0;
    cmd_bus.wait_slot    <= '0;
    cmd_bus.age_ms       <= '0;
    stall_cycles         = 0;
    tx_gaps              = 1'b1;
    rx_gaps              = 1'b1;
    hold_req             = 1'b0;
    cur_limit            = STALE_LIMIT_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands under the reset stale limit.
    send_fields(OP_INIT, 8'd0, 8'd0, 2'd0, 32'd0);
    send_fields(OP_SHOW_WAIT, 8'd0, 8'd5, 2'd3, 32'd0);
    send_fields(OP_SHOW_WAIT, 8'd7, 8'd3, 2'd1, STALE_LIMIT_RST);
    send_fields(OP_SHOW_WAIT, 8'd42, 8'd59, 2'd2, STALE_LIMIT_RST + 32'd1);
    send_fields(OP_SHOW_WAIT, 8'd255, 8'd100, 2'd0, 32'hFFFF_FFFF);
    send_fields(OP_SHOW_WAIT, 8'd100, 8'd255, 2'd3, 32'd0);
    send_fields(OP_SHOW_WAIT, 8'd99, 8'd99, 2'd2, 32'd59999);
    send_fields(OP_SHOW_WAIT, 8'd10, 8'd10, 2'd1, 32'd1);
    send_fields(OP_SHOW_WAIT, 8'd9, 8'd9, 2'd0, 32'd0);
    send_fields(OP_SHOW_WAIT, 8'd1, 8'd0, 2'd0, 32'd0);
    send_fields(OP_SET_DOT, 8'hFF, 8'hFF, 2'd3, 32'hFFFF_FFFF);
    send_fields(OP_TOG_COLON, 8'd0, 8'd0, 2'd0, 32'd0);
    send_fields(OP_TOG_COLON, 8'd0, 8'd0, 2'd0, 32'd0);
    send_fields(OP_SHOW_WAIT, 8'd12, 8'd200, 2'd3, 32'h8000_0000);
    send_fields(OP_CLR_DOT, 8'd0, 8'd0, 2'd0, 32'd0);
    send_fields(OP_ERROR, 8'd0, 8'd0, 2'd0, 32'd0);
    send_fields(OP_ROUTER, 8'd0, 8'd0, 2'd0, 32'd0);
    send_fields(OP_DHCP, 8'd0, 8'd0, 2'd0, 32'd0);
    send_fields(4'd9, 8'd33, 8'd44, 2'd1, 32'd0);
    send_fields(4'd15, 8'd0, 8'd0, 2'd0, 32'hFFFF_FFFF);
    send_fields(OP_CLEAR, 8'd0, 8'd0, 2'd0, 32'd0);
    send_fields(OP_SHOW_WAIT, 8'd0, 8'd0, 2'd2, 32'd70000);

    // Random phases, run under a series of stale limits.
    random_phase(PHASE_ITEMS);

    write_stale_limit(32'd0);
    random_phase(PHASE_ITEMS / 2);
    // Long receiver hold-off while the sender keeps offering commands.
    tx_gaps  = 1'b0;
    hold_req = 1'b1;
    random_phase(40);
    tx_gaps = 1'b1;
    random_phase(PHASE_ITEMS / 2);

    write_stale_limit(32'hFFFF_FFFF);
    // A stretch with no idling on either side.
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    random_phase(100);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    random_phase(PHASE_ITEMS / 2);

    write_stale_limit($urandom);
    random_phase(PHASE_ITEMS);

    write_stale_limit(32'd1000 + 32'($urandom_range(500)));
    random_phase(PHASE_ITEMS);

    drain();
    if (board.errors == 0) begin
      $display("tb_seven_segment_status_display: clean");
    end else begin
      $display("tb_seven_segment_status_display: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+src
src/sssd_pkg.sv
src/sssd_cmd_if.sv
src/sssd_disp_if.sv
src/sssd_in_stage.sv
src/sssd_next.sv
src/seven_segment_status_display.sv
tb/tb_seven_segment_status_display.sv
